### rtl/plp_pkg.sv
// Shared constants, types and small helpers for the pathway lasso proximal block.
// No dependencies; imported by plp_mul, plp_div and pathway_lasso_prox.
package plp_pkg;

  // Fixed-point format of every value.
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int CASE_W    = 3;
  localparam int CFG_IDX_W = 3;

  // Multiplier: signed operands wide enough for mu, phi and their offsets.
  localparam int OPW     = 51;
  localparam int MAGW    = OPW - 1;
  localparam int HALFW   = MAGW / 2;
  localparam int PRODW   = 2 * MAGW;
  localparam int MRES_W  = 63;
  localparam int MUL_LAT = 5;
  localparam logic [MRES_W-2:0] PROD_CAP = {1'b1, {(MRES_W-2){1'b0}}};

  // Divider: signed 64-bit numerator and denominator, 32 quotient bits.
  localparam int DIV_IN_W = 64;
  localparam int DMAG_W   = DIV_IN_W - 1;
  localparam int QBITS    = DATA_W;
  localparam int DIV_LAT  = QBITS + 3;
  localparam logic [DATA_W-1:0] LIM_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] LIM_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RHO   = 3'd0,
    REG_L1A   = 3'd1,
    REG_L1B   = 3'd2,
    REG_L2A   = 3'd3,
    REG_L2B   = 3'd4,
    REG_KAPPA = 3'd5
  } reg_idx_t;

  // Which branch of the proximal solve produced the result.
  typedef enum logic [CASE_W-1:0] {
    CASE_UNCOUPLED = 3'd0,
    CASE_PP        = 3'd1,
    CASE_PN        = 3'd2,
    CASE_NP        = 3'd3,
    CASE_NN        = 3'd4,
    CASE_ALPHA     = 3'd5,
    CASE_BETA      = 3'd6,
    CASE_ZERO      = 3'd7
  } case_t;

  // Unsigned register value as a multiplier operand.
  function automatic logic signed [OPW-1:0] u2op(input logic [DATA_W-1:0] v);
    return OPW'({1'b0, v});
  endfunction

  // Signed input field as a multiplier operand.
  function automatic logic signed [OPW-1:0] s2op(input logic signed [DATA_W-1:0] v);
    return OPW'(v);
  endfunction

  // Product widened to a divider operand.
  function automatic logic signed [DIV_IN_W-1:0] p2d(input logic signed [MRES_W-1:0] v);
    return DIV_IN_W'(v);
  endfunction

endpackage

### rtl/plp_mul.sv
// Pipelined signed fixed-point multiplier with magnitude clamp (five stages).
// Depends on plp_pkg for widths, the fraction size and the clamp value.
module plp_mul (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [plp_pkg::OPW-1:0]     op_a,
  input  logic signed [plp_pkg::OPW-1:0]     op_b,
  output logic signed [plp_pkg::MRES_W-1:0]  prod,
  output logic                               sat
);
  import plp_pkg::*;

  logic [MAGW-1:0]    ma_r, mb_r;
  logic               neg1_r, neg2_r, neg3_r, neg4_r;
  logic [2*HALFW-1:0] p00_r, p01_r, p10_r, p11_r, p11b_r;
  logic [PRODW-1:0]   part_r, full_r;
  logic signed [MRES_W-1:0] prod_r;
  logic               sat_r;

  logic [OPW-1:0]     abs_a, abs_b;
  logic [PRODW-1:0]   sh;
  logic               big;
  logic [MRES_W-2:0]  res;

  // Stage one: magnitudes and result sign.
  always_comb begin
    abs_a = op_a[OPW-1] ? -op_a : op_a;
    abs_b = op_b[OPW-1] ? -op_b : op_b;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r   <= abs_a[MAGW-1:0];
      mb_r   <= abs_b[MAGW-1:0];
      neg1_r <= op_a[OPW-1] ^ op_b[OPW-1];
    end
  end

  // Stage two: four half-width partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      p00_r  <= ma_r[HALFW-1:0] * mb_r[HALFW-1:0];
      p01_r  <= ma_r[HALFW-1:0] * mb_r[MAGW-1:HALFW];
      p10_r  <= ma_r[MAGW-1:HALFW] * mb_r[HALFW-1:0];
      p11_r  <= ma_r[MAGW-1:HALFW] * mb_r[MAGW-1:HALFW];
      neg2_r <= neg1_r;
    end
  end

  // Stage three: fold the low and cross terms.
  always_ff @(posedge clk) begin
    if (en) begin
      part_r <= PRODW'(p00_r) + (PRODW'(p01_r) << HALFW) + (PRODW'(p10_r) << HALFW);
      p11b_r <= p11_r;
      neg3_r <= neg2_r;
    end
  end

  // Stage four: add the high term.
  always_ff @(posedge clk) begin
    if (en) begin
      full_r <= part_r + (PRODW'(p11b_r) << (2 * HALFW));
      neg4_r <= neg3_r;
    end
  end

  // Stage five: drop the fraction, clamp the magnitude and apply the sign.
  always_comb begin
    sh  = full_r >> FRAC_BITS;
    big = sh > PRODW'(PROD_CAP);
    res = big ? PROD_CAP : sh[MRES_W-2:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= neg4_r ? -MRES_W'(res) : MRES_W'(res);
      sat_r  <= big;
    end
  end

  assign prod = prod_r;
  assign sat  = sat_r;

endmodule

### rtl/plp_div.sv
// Pipelined restoring divider: one quotient bit per stage, clamped to 32 bits signed.
// Depends on plp_pkg for widths, the fraction size and the clamp limits.
module plp_div (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [plp_pkg::DIV_IN_W-1:0]  num,
  input  logic signed [plp_pkg::DIV_IN_W-1:0]  den,
  output logic signed [plp_pkg::DATA_W-1:0]    quot,
  output logic                                 sat
);
  import plp_pkg::*;

  localparam int RW  = DMAG_W + 1;
  localparam int OVW = DMAG_W + FRAC_BITS;
  localparam int CW  = DMAG_W + QBITS;

  logic [DMAG_W-1:0]   un_r, ud_r;
  logic                neg0_r, nz0_r;

  logic [RW-1:0]       rem_r  [QBITS+1];
  logic [QBITS-1:0]    nbit_r [QBITS+1];
  logic [QBITS-1:0]    quo_r  [QBITS+1];
  logic [DMAG_W-1:0]   dsr_r  [QBITS+1];
  logic                neg_r  [QBITS+1];
  logic                nz_r   [QBITS+1];
  logic                ovf_r  [QBITS+1];

  logic signed [DATA_W-1:0] quot_r;
  logic                sat_r;

  logic [DIV_IN_W-1:0] abs_n, abs_d;
  logic [OVW-1:0]      nfull;
  logic [DATA_W-1:0]   lim, qc;
  logic                clamp;

  // Stage zero: magnitudes and flags.
  always_comb begin
    abs_n = num[DIV_IN_W-1] ? -num : num;
    abs_d = den[DIV_IN_W-1] ? -den : den;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      un_r   <= abs_n[DMAG_W-1:0];
      ud_r   <= abs_d[DMAG_W-1:0];
      neg0_r <= num[DIV_IN_W-1] ^ den[DIV_IN_W-1];
      nz0_r  <= (num == '0);
    end
  end

  // Stage one: overflow test and initial partial remainder.
  assign nfull = OVW'(un_r) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= RW'(nfull >> QBITS);
      nbit_r[0] <= nfull[QBITS-1:0];
      quo_r[0]  <= '0;
      dsr_r[0]  <= ud_r;
      neg_r[0]  <= neg0_r;
      nz_r[0]   <= nz0_r;
      ovf_r[0]  <= CW'(nfull) >= (CW'(ud_r) << QBITS);
    end
  end

  // One restoring step per stage.
  for (genvar j = 0; j < QBITS; j++) begin : g_step
    logic [RW-1:0] shr;
    logic          ge;

    assign shr = {rem_r[j][RW-2:0], nbit_r[j][QBITS-1]};
    assign ge  = shr >= RW'(dsr_r[j]);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1]  <= ge ? shr - RW'(dsr_r[j]) : shr;
        nbit_r[j+1] <= {nbit_r[j][QBITS-2:0], 1'b0};
        quo_r[j+1]  <= {quo_r[j][QBITS-2:0], ge};
        dsr_r[j+1]  <= dsr_r[j];
        neg_r[j+1]  <= neg_r[j];
        nz_r[j+1]   <= nz_r[j];
        ovf_r[j+1]  <= ovf_r[j];
      end
    end
  end

  // Final stage: clamp to the signed range of the sign and apply it; a zero numerator gives zero.
  always_comb begin
    lim   = neg_r[QBITS] ? LIM_NEG : LIM_POS;
    clamp = ovf_r[QBITS] || (quo_r[QBITS] > lim);
    qc    = clamp ? lim : quo_r[QBITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (nz_r[QBITS]) begin
        quot_r <= '0;
        sat_r  <= 1'b0;
      end else begin
        quot_r <= neg_r[QBITS] ? -qc : qc;
        sat_r  <= clamp;
      end
    end
  end

  assign quot = quot_r;
  assign sat  = sat_r;

endmodule

### rtl/pathway_lasso_prox.sv
// Pathway lasso proximal step for one (alpha, beta) coefficient pair per request.
// Depends on plp_pkg, plp_mul and plp_div.
//
// Usage:
//   Configuration: write rho_penalty, l1_alpha, l1_beta, l2_alpha, l2_beta and
//   coupling_kappa through cfg_we / cfg_index / cfg_wdata while no request is in
//   flight. Each write takes effect at the clock edge at which cfg_we is high.
//   Input channel: a request is taken at a rising edge with in_valid high and
//   in_stall low. Output channel: a result is taken with out_valid high and
//   out_stall low.
//   Throughput: one request per cycle while out_stall does not hold a result,
//   through a fully pipelined datapath (two five-stage multiplier banks and
//   two 35-stage dividers).
//   Reset (rst_n low, synchronous) empties the pipeline and restores the
//   register defaults: rho one, every other weight zero.
//   Stall: while a result waits on out_stall, every stage holds and in_stall
//   is raised; an empty output slot lets the pipeline keep moving.
module pathway_lasso_prox (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [plp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [plp_pkg::DATA_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [plp_pkg::DATA_W-1:0]   in_dual_alpha,
  input  logic signed [plp_pkg::DATA_W-1:0]   in_local_alpha,
  input  logic signed [plp_pkg::DATA_W-1:0]   in_dual_beta,
  input  logic signed [plp_pkg::DATA_W-1:0]   in_local_beta,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [plp_pkg::DATA_W-1:0]   out_alpha_out,
  output logic signed [plp_pkg::DATA_W-1:0]   out_beta_out,
  output logic [plp_pkg::CASE_W-1:0]          out_case_taken,
  output logic                                out_saturated
);
  import plp_pkg::*;

  localparam int TOT = 2 * MUL_LAT + DIV_LAT + 6;
  localparam int NM1 = 4;
  localparam int NM2 = 18;

  typedef logic signed [OPW-1:0]      op_t;
  typedef logic signed [MRES_W-1:0]   prd_t;
  typedef logic signed [DIV_IN_W-1:0] dv_t;

  typedef struct packed {
    op_t  ta;
    op_t  tb;
    op_t  phi_a;
    op_t  phi_b;
    logic neg_a;
    logic neg_b;
    logic sat;
  } side_t;

  typedef struct packed {
    dv_t  den;
    dv_t  num_a;
    dv_t  num_b;
    dv_t  lhs5;
    dv_t  rhs5;
    dv_t  lhs6;
    dv_t  rhs6;
    dv_t  phi_a;
    dv_t  phi_b;
    logic tpos_a;
    logic tpos_b;
    logic sat_in;
    logic sat_base;
    logic sat5;
    logic sat6;
  } t3_t;

  typedef struct packed {
    case_t cs;
    logic  sat;
  } aux_t;

  // Configuration registers.
  logic [DATA_W-1:0] rho_r, l1a_r, l1b_r, l2a_r, l2b_r, kappa_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rho_r   <= DATA_W'(1) << FRAC_BITS;
      l1a_r   <= '0;
      l1b_r   <= '0;
      l2a_r   <= '0;
      l2b_r   <= '0;
      kappa_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RHO:   rho_r   <= cfg_wdata;
        REG_L1A:   l1a_r   <= cfg_wdata;
        REG_L1B:   l1b_r   <= cfg_wdata;
        REG_L2A:   l2a_r   <= cfg_wdata;
        REG_L2B:   l2b_r   <= cfg_wdata;
        REG_KAPPA: kappa_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline advance and valid bits.
  logic vld_r [TOT];
  logic en;

  assign en        = !vld_r[TOT-1] || !out_stall;
  assign in_stall  = !en;
  assign out_valid = vld_r[TOT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < TOT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // Input register.
  logic signed [DATA_W-1:0] da_r, la_r, db_r, lb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      da_r <= in_dual_alpha;
      la_r <= in_local_alpha;
      db_r <= in_dual_beta;
      lb_r <= in_local_beta;
    end
  end

  // First multiplier bank: rho times the local estimates, kappa times the L2 weights.
  op_t  m1a [NM1];
  op_t  m1b [NM1];
  prd_t p1  [NM1];
  logic s1  [NM1];

  always_comb begin
    m1a[0] = u2op(rho_r);   m1b[0] = s2op(la_r);
    m1a[1] = u2op(rho_r);   m1b[1] = s2op(lb_r);
    m1a[2] = u2op(kappa_r); m1b[2] = u2op(l2a_r);
    m1a[3] = u2op(kappa_r); m1b[3] = u2op(l2b_r);
  end

  for (genvar g = 0; g < NM1; g++) begin : g_mul1
    plp_mul u_mul (
      .clk  (clk),
      .en   (en),
      .op_a (m1a[g]),
      .op_b (m1b[g]),
      .prod (p1[g]),
      .sat  (s1[g])
    );
  end

  // The dual values ride alongside the first bank.
  logic signed [DATA_W-1:0] dda_r [MUL_LAT];
  logic signed [DATA_W-1:0] ddb_r [MUL_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      dda_r[0] <= da_r;
      ddb_r[0] <= db_r;
      for (int i = 1; i < MUL_LAT; i++) begin
        dda_r[i] <= dda_r[i-1];
        ddb_r[i] <= ddb_r[i-1];
      end
    end
  end

  // Stage T1: mu and phi.
  op_t  mua_r, mub_r, phia_r, phib_r;
  logic sat1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mua_r  <= s2op(dda_r[MUL_LAT-1]) + OPW'(p1[0]);
      mub_r  <= s2op(ddb_r[MUL_LAT-1]) + OPW'(p1[1]);
      phia_r <= (OPW'(p1[2]) <<< 1) + u2op(rho_r);
      phib_r <= (OPW'(p1[3]) <<< 1) + u2op(rho_r);
      sat1_r <= s1[0] | s1[1] | s1[2] | s1[3];
    end
  end

  // Stage T2: shifted means, magnitudes and thresholds.
  op_t   l1a_op, l1b_op, abs_a, abs_b;
  op_t   x1_r, x2_r, y1_r, y2_r, absa_r, absb_r;
  side_t side_nxt, side_r;

  always_comb begin
    l1a_op = u2op(l1a_r);
    l1b_op = u2op(l1b_r);
    abs_a  = mua_r[OPW-1] ? -mua_r : mua_r;
    abs_b  = mub_r[OPW-1] ? -mub_r : mub_r;
    side_nxt.ta    = abs_a - l1a_op;
    side_nxt.tb    = abs_b - l1b_op;
    side_nxt.phi_a = phia_r;
    side_nxt.phi_b = phib_r;
    side_nxt.neg_a = mua_r[OPW-1];
    side_nxt.neg_b = mub_r[OPW-1];
    side_nxt.sat   = sat1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r   <= mua_r - l1a_op;
      x2_r   <= mua_r + l1a_op;
      y1_r   <= mub_r - l1b_op;
      y2_r   <= mub_r + l1b_op;
      absa_r <= abs_a;
      absb_r <= abs_b;
      side_r <= side_nxt;
    end
  end

  // Second multiplier bank: every product any branch of the solve can use.
  op_t  m2a [NM2];
  op_t  m2b [NM2];
  prd_t p2  [NM2];
  logic s2  [NM2];
  op_t  k_op;

  assign k_op = u2op(kappa_r);

  always_comb begin
    m2a[0]  = side_r.phi_a; m2b[0]  = side_r.phi_b;
    m2a[1]  = k_op;         m2b[1]  = k_op;
    m2a[2]  = side_r.phi_b; m2b[2]  = x1_r;
    m2a[3]  = side_r.phi_b; m2b[3]  = x2_r;
    m2a[4]  = side_r.phi_a; m2b[4]  = y1_r;
    m2a[5]  = side_r.phi_a; m2b[5]  = y2_r;
    m2a[6]  = k_op;         m2b[6]  = x1_r;
    m2a[7]  = k_op;         m2b[7]  = x2_r;
    m2a[8]  = k_op;         m2b[8]  = y1_r;
    m2a[9]  = k_op;         m2b[9]  = y2_r;
    m2a[10] = side_r.phi_a; m2b[10] = absb_r;
    m2a[11] = k_op;         m2b[11] = absa_r;
    m2a[12] = side_r.phi_a; m2b[12] = l1b_op;
    m2a[13] = k_op;         m2b[13] = l1a_op;
    m2a[14] = side_r.phi_b; m2b[14] = absa_r;
    m2a[15] = k_op;         m2b[15] = absb_r;
    m2a[16] = side_r.phi_b; m2b[16] = l1a_op;
    m2a[17] = k_op;         m2b[17] = l1b_op;
  end

  for (genvar g = 0; g < NM2; g++) begin : g_mul2
    plp_mul u_mul (
      .clk  (clk),
      .en   (en),
      .op_a (m2a[g]),
      .op_b (m2b[g]),
      .prod (p2[g]),
      .sat  (s2[g])
    );
  end

  side_t sd_r [MUL_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= side_r;
      for (int i = 1; i < MUL_LAT; i++) sd_r[i] <= sd_r[i-1];
    end
  end

  // Stage T3: determinant, quadrant numerators and single-nonzero tests.
  side_t sd;
  t3_t   t3_nxt, t3_r;
  dv_t   na_nxt [4];
  dv_t   nb_nxt [4];
  logic  sq_nxt [4];
  dv_t   na_r   [4];
  dv_t   nb_r   [4];
  logic  sq_r   [4];
  logic  tpa, tpb;

  assign sd = sd_r[MUL_LAT-1];

  always_comb begin
    tpa = !sd.ta[OPW-1] && (sd.ta != '0);
    tpb = !sd.tb[OPW-1] && (sd.tb != '0);
    t3_nxt.den      = p2d(p2[0]) - p2d(p2[1]);
    t3_nxt.num_a    = tpa ? (sd.neg_a ? -DIV_IN_W'(sd.ta) : DIV_IN_W'(sd.ta)) : '0;
    t3_nxt.num_b    = tpb ? (sd.neg_b ? -DIV_IN_W'(sd.tb) : DIV_IN_W'(sd.tb)) : '0;
    t3_nxt.lhs5     = p2d(p2[10]) - p2d(p2[11]);
    t3_nxt.rhs5     = p2d(p2[12]) - p2d(p2[13]);
    t3_nxt.lhs6     = p2d(p2[14]) - p2d(p2[15]);
    t3_nxt.rhs6     = p2d(p2[16]) - p2d(p2[17]);
    t3_nxt.phi_a    = DIV_IN_W'(sd.phi_a);
    t3_nxt.phi_b    = DIV_IN_W'(sd.phi_b);
    t3_nxt.tpos_a   = tpa;
    t3_nxt.tpos_b   = tpb;
    t3_nxt.sat_in   = sd.sat;
    t3_nxt.sat_base = s2[0] | s2[1];
    t3_nxt.sat5     = s2[10] | s2[11] | s2[12] | s2[13];
    t3_nxt.sat6     = s2[14] | s2[15] | s2[16] | s2[17];

    // Quadrants in trial order: ++, +-, -+, --.
    na_nxt[0] = p2d(p2[2]) - p2d(p2[8]);
    nb_nxt[0] = p2d(p2[4]) - p2d(p2[6]);
    na_nxt[1] = p2d(p2[2]) + p2d(p2[9]);
    nb_nxt[1] = p2d(p2[5]) + p2d(p2[6]);
    na_nxt[2] = p2d(p2[3]) + p2d(p2[8]);
    nb_nxt[2] = p2d(p2[4]) + p2d(p2[7]);
    na_nxt[3] = p2d(p2[3]) - p2d(p2[9]);
    nb_nxt[3] = p2d(p2[5]) - p2d(p2[7]);
    sq_nxt[0] = s2[2] | s2[8] | s2[4] | s2[6];
    sq_nxt[1] = s2[2] | s2[9] | s2[5] | s2[6];
    sq_nxt[2] = s2[3] | s2[8] | s2[4] | s2[7];
    sq_nxt[3] = s2[3] | s2[9] | s2[5] | s2[7];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3_r <= t3_nxt;
      for (int i = 0; i < 4; i++) begin
        na_r[i] <= na_nxt[i];
        nb_r[i] <= nb_nxt[i];
        sq_r[i] <= sq_nxt[i];
      end
    end
  end

  // Stage T4: pick the branch and the divider operands.
  logic c1, c2, c3, c4, c5, c6;
  dv_t  dna_nxt, dda_nxt, dnb_nxt, ddb_nxt;
  aux_t aux_nxt;
  dv_t  dna_r, dda4_r, dnb_r, ddb4_r;
  aux_t aux_r;

  always_comb begin
    c1 = !na_r[0][DIV_IN_W-1] && (na_r[0] != '0) &&
         !nb_r[0][DIV_IN_W-1] && (nb_r[0] != '0);
    c2 = !na_r[1][DIV_IN_W-1] && (na_r[1] != '0) && nb_r[1][DIV_IN_W-1];
    c3 = na_r[2][DIV_IN_W-1] && !nb_r[2][DIV_IN_W-1] && (nb_r[2] != '0);
    c4 = na_r[3][DIV_IN_W-1] && nb_r[3][DIV_IN_W-1];
    c5 = t3_r.tpos_a && (t3_r.lhs5 <= t3_r.rhs5);
    c6 = t3_r.tpos_b && (t3_r.lhs6 <= t3_r.rhs6);

    dna_nxt     = '0;
    dnb_nxt     = '0;
    dda_nxt     = t3_r.phi_a;
    ddb_nxt     = t3_r.phi_b;
    aux_nxt.cs  = CASE_ZERO;
    aux_nxt.sat = t3_r.sat_in;

    if (kappa_r == '0) begin
      // Separate soft thresholding.
      aux_nxt.cs = CASE_UNCOUPLED;
      dna_nxt    = t3_r.num_a;
      dnb_nxt    = t3_r.num_b;
    end else begin
      // Each quadrant tried adds its products to the clamp flag.
      aux_nxt.sat = t3_r.sat_in | t3_r.sat_base | sq_r[0] |
                    (!c1 & sq_r[1]) | (!c1 & !c2 & sq_r[2]) |
                    (!c1 & !c2 & !c3 & sq_r[3]);
      priority if (c1) begin
        aux_nxt.cs = CASE_PP;
        dna_nxt = na_r[0]; dnb_nxt = nb_r[0];
        dda_nxt = t3_r.den; ddb_nxt = t3_r.den;
      end else if (c2) begin
        aux_nxt.cs = CASE_PN;
        dna_nxt = na_r[1]; dnb_nxt = nb_r[1];
        dda_nxt = t3_r.den; ddb_nxt = t3_r.den;
      end else if (c3) begin
        aux_nxt.cs = CASE_NP;
        dna_nxt = na_r[2]; dnb_nxt = nb_r[2];
        dda_nxt = t3_r.den; ddb_nxt = t3_r.den;
      end else if (c4) begin
        aux_nxt.cs = CASE_NN;
        dna_nxt = na_r[3]; dnb_nxt = nb_r[3];
        dda_nxt = t3_r.den; ddb_nxt = t3_r.den;
      end else begin
        // Single-nonzero tests, each counted only when its threshold is positive.
        aux_nxt.sat = aux_nxt.sat | (t3_r.tpos_a & t3_r.sat5) |
                      (!c5 & t3_r.tpos_b & t3_r.sat6);
        priority if (c5) begin
          aux_nxt.cs = CASE_ALPHA;
          dna_nxt    = t3_r.num_a;
        end else if (c6) begin
          aux_nxt.cs = CASE_BETA;
          dnb_nxt    = t3_r.num_b;
        end else begin
          aux_nxt.cs = CASE_ZERO;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dna_r  <= dna_nxt;
      dda4_r <= dda_nxt;
      dnb_r  <= dnb_nxt;
      ddb4_r <= ddb_nxt;
      aux_r  <= aux_nxt;
    end
  end

  // Two dividers, one per coefficient.
  logic signed [DATA_W-1:0] qa, qb;
  logic                     sa, sb;

  plp_div u_div_a (
    .clk  (clk),
    .en   (en),
    .num  (dna_r),
    .den  (dda4_r),
    .quot (qa),
    .sat  (sa)
  );

  plp_div u_div_b (
    .clk  (clk),
    .en   (en),
    .num  (dnb_r),
    .den  (ddb4_r),
    .quot (qb),
    .sat  (sb)
  );

  aux_t ad_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      ad_r[0] <= aux_r;
      for (int i = 1; i < DIV_LAT; i++) ad_r[i] <= ad_r[i-1];
    end
  end

  // Output register.
  logic signed [DATA_W-1:0] oa_r, ob_r;
  logic [CASE_W-1:0]        ocs_r;
  logic                     osat_r;

  always_ff @(posedge clk) begin
    if (en) begin
      oa_r   <= qa;
      ob_r   <= qb;
      ocs_r  <= ad_r[DIV_LAT-1].cs;
      osat_r <= ad_r[DIV_LAT-1].sat | sa | sb;
    end
  end

  assign out_alpha_out  = oa_r;
  assign out_beta_out   = ob_r;
  assign out_case_taken = ocs_r;
  assign out_saturated  = osat_r;

endmodule
